[rtl/bpt_pkg.sv]
// Shared widths, register codes and payload types of the barometer compensation pipeline.
`default_nettype none

package bpt_pkg;

  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Temperature difference from the reference: D2 - C5 * 2^8.
  localparam int DT_W   = RAW_W + 1;
  // Temperature in centidegrees before and after the second-order term.
  localparam int TEMP_W = 20;
  // Offset and sensitivity, including their second-order corrections.
  localparam int WIDE_W = 42;
  // dT^2 >> 31 never exceeds 2^17.
  localparam int T2_W   = 19;

  localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};

  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -20'sd1500;

  // Calibration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_C1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C6 = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } coef_t;

  // First-order results plus what the second-order correction needs.
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic                     err;
    logic signed [TEMP_W-1:0] temp;
    logic signed [WIDE_W-1:0] off;
    logic signed [WIDE_W-1:0] sens;
    logic [T2_W-1:0]          t2;
    logic signed [TEMP_W-1:0] dwarm;
    logic signed [TEMP_W-1:0] dcold;
    logic                     lo;
    logic                     vlo;
  } first_t;

  // Fully corrected temperature, offset and sensitivity.
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic                     err;
    logic signed [TEMP_W-1:0] temp;
    logic signed [WIDE_W-1:0] off;
    logic signed [WIDE_W-1:0] sens;
  } second_t;

endpackage

`default_nettype wire

[rtl/bpt_ifs.sv]
// Channel interfaces for raw samples, compensated results and calibration writes.
`default_nettype none

interface bpt_sample_if;
  logic                        valid;
  logic                        ready;
  logic [bpt_pkg::RAW_W-1:0]   pressure_raw;
  logic [bpt_pkg::RAW_W-1:0]   temperature_raw;

  modport source (output valid, output pressure_raw, output temperature_raw, input ready);
  modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface bpt_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [bpt_pkg::OUT_W-1:0]  temperature_centideg;
  logic signed [bpt_pkg::OUT_W-1:0]  pressure_pascal;
  logic                              read_error;

  modport source (output valid, output temperature_centideg, output pressure_pascal,
                  output read_error, input ready);
  modport sink   (input valid, input temperature_centideg, input pressure_pascal,
                  input read_error, output ready);
endinterface

interface bpt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bpt_pkg::CFG_IDX_W-1:0]   index;
  logic [bpt_pkg::COEF_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/bpt_first_order.sv]
// Three-stage first-order compensation: dT, the dT products, then TEMP, OFF and SENS.
`default_nettype none

module bpt_first_order (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bpt_pkg::RAW_W-1:0]     d1,
  input  logic [bpt_pkg::RAW_W-1:0]     d2,
  input  bpt_pkg::coef_t                coef,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bpt_pkg::first_t               res
);

  localparam int PROD_W = bpt_pkg::DT_W + bpt_pkg::COEF_W + 1;
  localparam int SQ_W   = 2 * bpt_pkg::DT_W;

  logic en1, en2, en3;

  logic                             s1_valid;
  logic [bpt_pkg::RAW_W-1:0]        s1_d1;
  logic                             s1_err;
  logic signed [bpt_pkg::DT_W-1:0]  s1_dt;

  logic                             s2_valid;
  logic [bpt_pkg::RAW_W-1:0]        s2_d1;
  logic                             s2_err;
  logic signed [PROD_W-1:0]         s2_p6;
  logic signed [PROD_W-1:0]         s2_p4;
  logic signed [PROD_W-1:0]         s2_p3;
  logic signed [SQ_W-1:0]           s2_pdd;

  logic signed [bpt_pkg::DT_W:0]      dt_full;
  logic                               raw_err;
  logic signed [PROD_W-1:0]           p6, p4, p3;
  logic signed [SQ_W-1:0]             pdd;
  logic signed [bpt_pkg::TEMP_W-1:0]  temp;
  logic signed [bpt_pkg::WIDE_W-1:0]  off, sens;

  assign en3      = !res_valid || res_ready;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  // Stage 1: range check of the raw words and dT.
  assign dt_full = $signed({2'b00, d2}) - $signed({2'b00, coef.c5, 8'h00});
  assign raw_err = (d1 == '0) || (d1 == bpt_pkg::RAW_MAX) ||
                   (d2 == '0) || (d2 == bpt_pkg::RAW_MAX);

  // Stage 2: the four products of dT.
  assign p6  = s1_dt * $signed({1'b0, coef.c6});
  assign p4  = s1_dt * $signed({1'b0, coef.c4});
  assign p3  = s1_dt * $signed({1'b0, coef.c3});
  assign pdd = s1_dt * s1_dt;

  // Stage 3: first-order temperature, offset and sensitivity.
  assign temp = bpt_pkg::TEMP_REF + bpt_pkg::TEMP_W'(s2_p6 >>> 23);
  assign off  = bpt_pkg::WIDE_W'($signed({1'b0, coef.c2, 16'h0000}))
              + bpt_pkg::WIDE_W'(s2_p4 >>> 7);
  assign sens = bpt_pkg::WIDE_W'($signed({1'b0, coef.c1, 15'h0000}))
              + bpt_pkg::WIDE_W'(s2_p3 >>> 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en1) s1_valid  <= in_valid;
      if (en2) s2_valid  <= s1_valid;
      if (en3) res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_d1  <= d1;
      s1_err <= raw_err;
      s1_dt  <= dt_full[bpt_pkg::DT_W-1:0];
    end
    if (en2) begin
      s2_d1  <= s1_d1;
      s2_err <= s1_err;
      s2_p6  <= p6;
      s2_p4  <= p4;
      s2_p3  <= p3;
      s2_pdd <= pdd;
    end
    if (en3) begin
      res.d1    <= s2_d1;
      res.err   <= s2_err;
      res.temp  <= temp;
      res.off   <= off;
      res.sens  <= sens;
      res.t2    <= bpt_pkg::T2_W'(s2_pdd >>> 31);
      res.dwarm <= temp - bpt_pkg::TEMP_REF;
      res.dcold <= temp - bpt_pkg::TEMP_COLD;
      res.lo    <= temp < bpt_pkg::TEMP_REF;
      res.vlo   <= temp < bpt_pkg::TEMP_COLD;
    end
  end

endmodule

`default_nettype wire

[rtl/bpt_second_order.sv]
// Three-stage second-order correction: squares, OFF2 and SENS2, then the subtractions.
`default_nettype none

module bpt_second_order (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpt_pkg::first_t   in_data,
  output logic              res_valid,
  input  logic              res_ready,
  output bpt_pkg::second_t  res
);

  localparam int SQT_W = 2 * bpt_pkg::TEMP_W;

  logic en1, en2, en3;

  logic                       s1_valid;
  bpt_pkg::first_t            s1_f;
  logic signed [SQT_W-1:0]    s1_sqw;
  logic signed [SQT_W-1:0]    s1_sqc;

  logic                       s2_valid;
  bpt_pkg::first_t            s2_f;
  logic [bpt_pkg::WIDE_W-1:0] s2_off2;
  logic [bpt_pkg::WIDE_W-1:0] s2_sens2;

  logic [bpt_pkg::WIDE_W-1:0] sw, sc, sw5, sc7, sc11;
  logic [bpt_pkg::WIDE_W-1:0] off2, sens2;

  assign en3      = !res_valid || res_ready;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  // Both squares are non-negative, so plain shifts round the same as the arithmetic ones.
  assign sw   = bpt_pkg::WIDE_W'($unsigned(s1_sqw));
  assign sc   = bpt_pkg::WIDE_W'($unsigned(s1_sqc));
  assign sw5  = (sw << 2) + sw;
  assign sc7  = (sc << 3) - sc;
  assign sc11 = (sc << 3) + (sc << 1) + sc;

  always_comb begin
    off2  = '0;
    sens2 = '0;
    if (s1_f.lo) begin
      off2  = sw5 >> 1;
      sens2 = sw5 >> 2;
      if (s1_f.vlo) begin
        off2  = off2 + sc7;
        sens2 = sens2 + (sc11 >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en1) s1_valid  <= in_valid;
      if (en2) s2_valid  <= s1_valid;
      if (en3) res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_f   <= in_data;
      s1_sqw <= in_data.dwarm * in_data.dwarm;
      s1_sqc <= in_data.dcold * in_data.dcold;
    end
    if (en2) begin
      s2_f     <= s1_f;
      s2_off2  <= off2;
      s2_sens2 <= sens2;
    end
    if (en3) begin
      res.d1   <= s2_f.d1;
      res.err  <= s2_f.err;
      res.temp <= s2_f.lo ? s2_f.temp - $signed(bpt_pkg::TEMP_W'(s2_f.t2)) : s2_f.temp;
      res.off  <= s2_f.off - $signed(s2_off2);
      res.sens <= s2_f.sens - $signed(s2_sens2);
    end
  end

endmodule

`default_nettype wire

[rtl/bpt_pressure.sv]
// Three-stage pressure output: split D1 * SENS product, shift, offset subtract and saturate.
`default_nettype none

module bpt_pressure (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bpt_pkg::second_t                  in_data,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic signed [bpt_pkg::OUT_W-1:0]  temperature_centideg,
  output logic signed [bpt_pkg::OUT_W-1:0]  pressure_pascal,
  output logic                              read_error
);

  // SENS is split into a low unsigned half and a high signed half.
  localparam int SPLIT_W  = bpt_pkg::WIDE_W / 2;
  localparam int HI_W     = bpt_pkg::WIDE_W - SPLIT_W;
  localparam int PLO_W    = bpt_pkg::RAW_W + SPLIT_W;
  localparam int PHI_W    = bpt_pkg::RAW_W + 1 + HI_W;
  localparam int FULL_W   = bpt_pkg::RAW_W + 1 + bpt_pkg::WIDE_W;
  localparam int PS_W     = FULL_W - 21;
  localparam int X_W      = PS_W + 1;
  localparam int PV_W     = X_W - 15;

  logic en1, en2, en3;

  logic                               s1_valid;
  logic                               s1_err;
  logic signed [bpt_pkg::TEMP_W-1:0]  s1_temp;
  logic signed [bpt_pkg::WIDE_W-1:0]  s1_off;
  logic [PLO_W-1:0]                   s1_plo;
  logic signed [PHI_W-1:0]            s1_phi;

  logic                               s2_valid;
  logic                               s2_err;
  logic signed [bpt_pkg::TEMP_W-1:0]  s2_temp;
  logic signed [bpt_pkg::WIDE_W-1:0]  s2_off;
  logic signed [PS_W-1:0]             s2_ps;

  logic signed [FULL_W-1:0]           full;
  logic signed [X_W-1:0]              x;
  logic signed [PV_W-1:0]             pv;
  logic signed [bpt_pkg::OUT_W-1:0]   p_sat;

  function automatic logic signed [bpt_pkg::OUT_W-1:0] sat_out(
    input logic signed [PV_W-1:0] v
  );
    logic signed [bpt_pkg::OUT_W-1:0] r;
    if ((&v[PV_W-1:bpt_pkg::OUT_W-1]) || !(|v[PV_W-1:bpt_pkg::OUT_W-1])) begin
      r = v[bpt_pkg::OUT_W-1:0];
    end else if (v[PV_W-1]) begin
      r = {1'b1, {(bpt_pkg::OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(bpt_pkg::OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign en3      = !res_valid || res_ready;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  assign full  = (FULL_W'(s1_phi) <<< SPLIT_W) + FULL_W'($signed({1'b0, s1_plo}));
  assign x     = X_W'(s2_ps) - X_W'(s2_off);
  assign pv    = PV_W'(x >>> 15);
  assign p_sat = sat_out(pv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en1) s1_valid  <= in_valid;
      if (en2) s2_valid  <= s1_valid;
      if (en3) res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_err  <= in_data.err;
      s1_temp <= in_data.temp;
      s1_off  <= in_data.off;
      s1_plo  <= in_data.d1 * in_data.sens[SPLIT_W-1:0];
      s1_phi  <= $signed({1'b0, in_data.d1}) *
                 $signed(in_data.sens[bpt_pkg::WIDE_W-1:SPLIT_W]);
    end
    if (en2) begin
      s2_err  <= s1_err;
      s2_temp <= s1_temp;
      s2_off  <= s1_off;
      s2_ps   <= PS_W'(full >>> 21);
    end
    if (en3) begin
      read_error           <= s2_err;
      // The corrected temperature always fits in 32 bits, so it is only sign-extended.
      temperature_centideg <= s2_err ? '0 : bpt_pkg::OUT_W'(s2_temp);
      pressure_pascal      <= s2_err ? '0 : p_sat;
    end
  end

endmodule

`default_nettype wire

[rtl/baro_pressure_temp_compensation.sv]
// Top level of the barometer temperature and pressure compensation pipeline.
// Each item is a raw pressure and temperature conversion pair; the block returns one result item
// per input item, in order. The nine register stages (three for first-order compensation, three
// for the second-order correction, three for the split pressure multiply and saturation) accept
// one item every cycle while the result side is ready, and each stage stalls on its own, so idle
// stages keep filling while a result waits.
// Calibration words C1..C6 are written at indexes 0..5 and are always accepted; write them only
// while no item is in flight. Writes to other indexes are ignored.
`default_nettype none

module baro_pressure_temp_compensation (
  input  logic          clk,
  input  logic          rst,
  bpt_sample_if.sink    sample,
  bpt_result_if.source  result,
  bpt_cfg_if.sink       cfg
);

  bpt_pkg::coef_t   coef;

  logic             fo_valid;
  logic             fo_ready;
  bpt_pkg::first_t  fo_data;

  logic             so_valid;
  logic             so_ready;
  bpt_pkg::second_t so_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        bpt_pkg::REG_C1: coef.c1 <= cfg.data;
        bpt_pkg::REG_C2: coef.c2 <= cfg.data;
        bpt_pkg::REG_C3: coef.c3 <= cfg.data;
        bpt_pkg::REG_C4: coef.c4 <= cfg.data;
        bpt_pkg::REG_C5: coef.c5 <= cfg.data;
        bpt_pkg::REG_C6: coef.c6 <= cfg.data;
        default: ;
      endcase
    end
  end

  bpt_first_order u_first (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .d1        (sample.pressure_raw),
    .d2        (sample.temperature_raw),
    .coef      (coef),
    .res_valid (fo_valid),
    .res_ready (fo_ready),
    .res       (fo_data)
  );

  bpt_second_order u_second (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fo_valid),
    .in_ready  (fo_ready),
    .in_data   (fo_data),
    .res_valid (so_valid),
    .res_ready (so_ready),
    .res       (so_data)
  );

  bpt_pressure u_pressure (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (so_valid),
    .in_ready             (so_ready),
    .in_data              (so_data),
    .res_valid            (result.valid),
    .res_ready            (result.ready),
    .temperature_centideg (result.temperature_centideg),
    .pressure_pascal      (result.pressure_pascal),
    .read_error           (result.read_error)
  );

endmodule

`default_nettype wire

[rtl/bpt_checker.sv]
// Port-level assertions for the compensation pipeline and their binding to the top level.
`default_nettype none

module bpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_temp,
  input logic [31:0] res_press,
  input logic        res_err
);

  // A result that is not taken stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result item dropped while stalled");

  // A stalled result keeps its payload.
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_temp) && $stable(res_press) && $stable(res_err))
    else $error("stalled result item changed");

  // An invalid raw word yields zeroed fields.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_err |-> res_temp == 32'd0 && res_press == 32'd0)
    else $error("error result item carries nonzero fields");

  // The corrected temperature stays strictly between -2^18 and 2^18.
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_err |->
      $signed(res_temp) < 32'sd262144 && $signed(res_temp) > -32'sd262144)
    else $error("temperature outside its reachable range");

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind baro_pressure_temp_compensation bpt_checker u_bpt_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_temp  (result.temperature_centideg),
  .res_press (result.pressure_pascal),
  .res_err   (result.read_error)
);

`default_nettype wire
